[rtl/htu_pkg.sv]
// Shared types and constants for the homeostatic threshold update block.
`default_nettype none

package htu_pkg;

    // Command codes carried in a request
    typedef enum logic [1:0] {
        CMD_SPIKE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WINDOW_DECAY      = 3'd0,
        CFG_HZ_PER_SPIKE      = 3'd1,
        CFG_TARGET_RATE       = 3'd2,
        CFG_GAIN              = 3'd3,
        CFG_THRESHOLD_FLOOR   = 3'd4,
        CFG_THRESHOLD_CEILING = 3'd5,
        CFG_UPDATE_INTERVAL   = 3'd6
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [15:0] WINDOW_DECAY_RST      = 16'd0;
    localparam logic [23:0] HZ_PER_SPIKE_RST      = 24'd256;
    localparam logic [23:0] TARGET_RATE_RST       = 24'd0;
    localparam logic [15:0] GAIN_RST              = 16'd0;
    localparam logic [23:0] THRESHOLD_FLOOR_RST   = 24'd0;
    localparam logic [23:0] THRESHOLD_CEILING_RST = 24'hFFFFFF;
    localparam logic [15:0] UPDATE_INTERVAL_RST   = 16'd1;

    localparam logic [23:0] RATE_MAX  = 24'hFFFFFF;
    localparam logic [15:0] TICK_MAX  = 16'hFFFF;

    // Input request
    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  neuron_id;
        logic [23:0] load_value;
    } req_t;

    // Result item
    typedef struct packed {
        logic [5:0]  out_neuron;
        logic [23:0] out_rate;
        logic [23:0] out_threshold;
        logic        last;
    } rsp_t;

    // Coefficients the update datapath needs
    typedef struct packed {
        logic [15:0] window_decay;
        logic [23:0] hz_per_spike;
        logic [23:0] target_rate;
        logic [15:0] gain;
        logic [23:0] threshold_floor;
        logic [23:0] threshold_ceiling;
    } coef_t;

    // Tag that follows one neuron through the update pipeline
    typedef struct packed {
        logic       valid;
        logic [5:0] idx;
        logic       last;
    } tag_t;

    // Write-back from the update pipeline
    typedef struct packed {
        tag_t        tag;
        logic [23:0] rate;
        logic [23:0] thr;
    } wb_t;

endpackage

`default_nettype wire

[rtl/homeostatic_threshold_update.sv]
// Top level: spike counting, threshold loads and window updates over per-neuron memories.
//
// Requests come in on start/request and are taken at an edge where start is
// high and busy is low. A spike, load or clear request gives no result;
// spikes may follow each other every cycle while busy is low, repeats on the
// same neuron are covered by a one-entry forward on the count memory.
// A tick that does not close a window gives no result either. A tick that
// closes a window starts a walk over all neurons: busy stays high until the
// last neuron has left the update pipeline, and one result per neuron, in
// index order, is strobed on result_valid for one cycle each, on consecutive
// cycles; result.last marks the final neuron. The walk rate is one neuron
// per cycle, set by the single read port of each state memory; each neuron
// passes through the memory read, the six-stage update pipeline and the
// result register. The receiver cannot stall results.
// Configuration writes use cfg_valid/cfg_ready (always ready) and take effect at once;
// the user must make them only while the block is idle; the block does not enforce it.
// Reset clears the window counter, the valid bits that stand for the
// cleared count, rate and threshold memories, and restores the
// configuration defaults; no clearing pass is needed.
`default_nettype none

module homeostatic_threshold_update #(
    parameter int NEURONS    = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire htu_pkg::req_t request,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [23:0]   cfg_data,
    output logic               result_valid,
    output htu_pkg::rsp_t      result
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers
    logic [15:0] window_decay_reg;
    logic [23:0] hz_per_spike_reg;
    logic [23:0] target_rate_reg;
    logic [15:0] gain_reg;
    logic [23:0] floor_reg;
    logic [23:0] ceiling_reg;
    logic [15:0] interval_reg;

    // State memories
    logic [COUNT_BITS-1:0] cnt_mem  [NEURONS];
    logic [23:0]           rate_mem [NEURONS];
    logic [23:0]           thr_mem  [NEURONS];

    logic [COUNT_BITS-1:0] cnt_rdata_reg;
    logic [23:0]           rate_rdata_reg, thr_rdata_reg;
    logic                  cnt_ok_reg, rate_ok_reg, thr_ok_reg;

    logic [NEURONS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [NEURONS-1:0] rate_vld_reg, rate_vld_next;
    logic [NEURONS-1:0] thr_vld_reg, thr_vld_next;

    // Control
    logic [15:0]   tick_reg, tick_next;
    logic          walk_on_reg, walk_on_next;
    logic [AW-1:0] walk_idx_reg, walk_idx_next;
    htu_pkg::tag_t rd_tag_reg, rd_tag_next;

    // Spike read-modify-write stage and its forward
    logic                  sp_valid_reg, sp_valid_next;
    logic [AW-1:0]         sp_addr_reg;
    logic                  lw_valid_reg;
    logic [AW-1:0]         lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;
    logic [COUNT_BITS-1:0] sp_cur, sp_new;

    logic          accept, in_range, is_spike, is_tick, is_load, is_clear;
    logic [15:0]   tick_inc;
    logic          tick_close;
    logic [AW-1:0] req_addr, rd_addr;
    logic          thr_we;
    logic [AW-1:0] thr_waddr, wb_addr;
    logic [23:0]   thr_wdata;

    htu_pkg::coef_t        coef;
    htu_pkg::wb_t          wb;
    logic                  pipe_busy;
    logic [COUNT_BITS-1:0] walk_count;

    // Request decode
    always_comb
    begin
        accept   = start && !busy;
        in_range = {1'b0, request.neuron_id} < 7'(NEURONS);
        req_addr = request.neuron_id[AW-1:0];
        is_spike = accept && (request.command == htu_pkg::CMD_SPIKE);
        is_tick  = accept && (request.command == htu_pkg::CMD_TICK);
        is_load  = accept && (request.command == htu_pkg::CMD_LOAD) && in_range;
        is_clear = accept && (request.command == htu_pkg::CMD_CLEAR);
        tick_inc = (tick_reg == htu_pkg::TICK_MAX) ? tick_reg : tick_reg + 16'd1;
        tick_close = is_tick && (tick_inc >= interval_reg);
    end

    assign busy      = walk_on_reg | rd_tag_reg.valid | pipe_busy;
    assign cfg_ready = 1'b1;
    assign rd_addr   = walk_on_reg ? walk_idx_reg : req_addr;
    assign wb_addr   = wb.tag.idx[AW-1:0];

    // Spike increment with forward from the previous cycle's write
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == sp_addr_reg))
        begin
            sp_cur = lw_data_reg;
        end
        else
        begin
            sp_cur = cnt_ok_reg ? cnt_rdata_reg : '0;
        end
        sp_new = (sp_cur == COUNT_MAX) ? sp_cur : sp_cur + COUNT_BITS'(1);
    end

    // Window counter and walk sequencing
    always_comb
    begin
        tick_next     = tick_reg;
        walk_on_next  = walk_on_reg;
        walk_idx_next = walk_idx_reg;
        sp_valid_next = is_spike && in_range;

        if (is_clear)
        begin
            tick_next = '0;
        end
        else if (is_tick)
        begin
            tick_next = tick_close ? 16'd0 : tick_inc;
        end

        if (tick_close)
        begin
            walk_on_next  = 1'b1;
            walk_idx_next = '0;
        end
        else if (walk_on_reg)
        begin
            if (walk_idx_reg == AW'(NEURONS - 1))
            begin
                walk_on_next = 1'b0;
            end
            else
            begin
                walk_idx_next = walk_idx_reg + AW'(1);
            end
        end

        rd_tag_next.valid = walk_on_reg;
        rd_tag_next.idx   = 6'(walk_idx_reg);
        rd_tag_next.last  = (walk_idx_reg == AW'(NEURONS - 1));
    end

    // Valid bits standing in for the reset value of each entry
    always_comb
    begin
        cnt_vld_next  = cnt_vld_reg;
        rate_vld_next = rate_vld_reg;
        thr_vld_next  = thr_vld_reg;
        if (sp_valid_reg)
        begin
            cnt_vld_next[sp_addr_reg] = 1'b1;
        end
        if (walk_on_reg)
        begin
            cnt_vld_next[walk_idx_reg] = 1'b0;
        end
        if (is_clear)
        begin
            cnt_vld_next = '0;
        end
        if (wb.tag.valid)
        begin
            rate_vld_next[wb_addr] = 1'b1;
            thr_vld_next[wb_addr]  = 1'b1;
        end
        if (is_load)
        begin
            thr_vld_next[req_addr] = 1'b1;
        end
    end

    // Threshold memory write select: load or write-back
    always_comb
    begin
        thr_we    = is_load || wb.tag.valid;
        thr_waddr = wb.tag.valid ? wb_addr : req_addr;
        thr_wdata = wb.tag.valid ? wb.thr : request.load_value;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            walk_on_reg  <= 1'b0;
            walk_idx_reg <= '0;
            rd_tag_reg   <= '0;
            sp_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            cnt_vld_reg  <= '0;
            rate_vld_reg <= '0;
            thr_vld_reg  <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            tick_reg     <= tick_next;
            walk_on_reg  <= walk_on_next;
            walk_idx_reg <= walk_idx_next;
            rd_tag_reg   <= rd_tag_next;
            sp_valid_reg <= sp_valid_next;
            lw_valid_reg <= sp_valid_reg;
            cnt_vld_reg  <= cnt_vld_next;
            rate_vld_reg <= rate_vld_next;
            thr_vld_reg  <= thr_vld_next;
            result_valid <= wb.tag.valid;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_decay_reg <= htu_pkg::WINDOW_DECAY_RST;
            hz_per_spike_reg <= htu_pkg::HZ_PER_SPIKE_RST;
            target_rate_reg  <= htu_pkg::TARGET_RATE_RST;
            gain_reg         <= htu_pkg::GAIN_RST;
            floor_reg        <= htu_pkg::THRESHOLD_FLOOR_RST;
            ceiling_reg      <= htu_pkg::THRESHOLD_CEILING_RST;
            interval_reg     <= htu_pkg::UPDATE_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                htu_pkg::CFG_WINDOW_DECAY:      window_decay_reg <= cfg_data[15:0];
                htu_pkg::CFG_HZ_PER_SPIKE:      hz_per_spike_reg <= cfg_data;
                htu_pkg::CFG_TARGET_RATE:       target_rate_reg  <= cfg_data;
                htu_pkg::CFG_GAIN:              gain_reg         <= cfg_data[15:0];
                htu_pkg::CFG_THRESHOLD_FLOOR:   floor_reg        <= cfg_data;
                htu_pkg::CFG_THRESHOLD_CEILING: ceiling_reg      <= cfg_data;
                htu_pkg::CFG_UPDATE_INTERVAL:   interval_reg     <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // Spike count memory
    always_ff @(posedge clk)
    begin
        if (sp_valid_reg)
        begin
            cnt_mem[sp_addr_reg] <= sp_new;
        end
        cnt_rdata_reg <= cnt_mem[rd_addr];
        cnt_ok_reg    <= cnt_vld_reg[rd_addr];
    end

    // Average rate memory
    always_ff @(posedge clk)
    begin
        if (wb.tag.valid)
        begin
            rate_mem[wb_addr] <= wb.rate;
        end
        rate_rdata_reg <= rate_mem[rd_addr];
        rate_ok_reg    <= rate_vld_reg[rd_addr];
    end

    // Threshold memory
    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_mem[thr_waddr] <= thr_wdata;
        end
        thr_rdata_reg <= thr_mem[rd_addr];
        thr_ok_reg    <= thr_vld_reg[rd_addr];
    end

    // Spike stage payload, forward entry and result register
    always_ff @(posedge clk)
    begin
        sp_addr_reg          <= req_addr;
        lw_addr_reg          <= sp_addr_reg;
        lw_data_reg          <= sp_new;
        result.out_neuron    <= wb.tag.idx;
        result.out_rate      <= wb.rate;
        result.out_threshold <= wb.thr;
        result.last          <= wb.tag.last;
    end

    // Update pipeline
    always_comb
    begin
        coef.window_decay      = window_decay_reg;
        coef.hz_per_spike      = hz_per_spike_reg;
        coef.target_rate       = target_rate_reg;
        coef.gain              = gain_reg;
        coef.threshold_floor   = floor_reg;
        coef.threshold_ceiling = ceiling_reg;
        walk_count             = cnt_ok_reg ? cnt_rdata_reg : '0;
    end

    htu_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .tag_in    (rd_tag_reg),
        .count_in  (walk_count),
        .avg_in    (rate_ok_reg ? rate_rdata_reg : 24'd0),
        .thr_in    (thr_ok_reg ? thr_rdata_reg : 24'd0),
        .wb        (wb),
        .pipe_busy (pipe_busy)
    );

    // Results only come out of a walk
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a walk in progress");

    // Walk results are contiguous up to the last neuron
    a_walk_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap inside an update walk");

    // Nothing follows the last neuron of a walk
    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result after the final neuron");

    // A closing tick makes the block busy
    a_close_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tick_close |=> (busy && walk_on_reg))
        else $error("window closed but no walk started");

endmodule

`default_nettype wire

[rtl/htu_datapath.sv]
// Six-stage update pipeline: observed rate, rate blend, threshold step and clamp.
`default_nettype none

module htu_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire htu_pkg::coef_t        coef,
    input  wire htu_pkg::tag_t         tag_in,
    input  wire logic [COUNT_BITS-1:0] count_in,
    input  wire logic [23:0]           avg_in,
    input  wire logic [23:0]           thr_in,
    output htu_pkg::wb_t               wb,
    output logic                       pipe_busy
);

    localparam int PW = COUNT_BITS + 24;

    htu_pkg::tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg, s6_tag_reg;

    logic [23:0]        s1_obs_reg, s1_avg_reg, s1_thr_reg;
    logic [39:0]        s2_pa_reg;
    logic [40:0]        s2_pb_reg;
    logic [23:0]        s2_thr_reg;
    logic [23:0]        s3_rate_reg, s3_thr_reg;
    logic [23:0]        s4_rate_reg, s4_thr_reg, s4_diff_reg;
    logic               s4_up_reg;
    logic [23:0]        s5_rate_reg, s5_thr_reg;
    logic [32:0]        s5_step_reg;
    logic               s5_up_reg;
    logic [23:0]        s6_rate_reg;
    logic signed [34:0] s6_thr_reg;

    logic [PW-1:0]      obs_prod;
    logic [23:0]        s1_obs_next;
    logic [16:0]        decay_comp;
    logic [39:0]        s2_pa_next;
    logic [40:0]        s2_pb_next;
    logic [40:0]        blend_sum;
    logic               s4_up_next;
    logic [23:0]        s4_diff_next;
    logic [39:0]        step_prod;
    logic [40:0]        step_round;
    logic signed [34:0] s6_thr_next;
    logic signed [34:0] floor_s, ceil_s, thr_lo;

    // Stage 1: observed rate, saturated to 24 bits
    always_comb
    begin
        obs_prod    = PW'(count_in) * PW'(coef.hz_per_spike);
        s1_obs_next = (|obs_prod[PW-1:24]) ? htu_pkg::RATE_MAX : obs_prod[23:0];
    end

    // Stage 2: the two blend products
    always_comb
    begin
        decay_comp = 17'h10000 - {1'b0, coef.window_decay};
        s2_pa_next = 40'(s1_avg_reg) * 40'(coef.window_decay);
        s2_pb_next = 41'(s1_obs_reg) * 41'(decay_comp);
    end

    // Stage 3: rounded blend
    assign blend_sum = {1'b0, s2_pa_reg} + s2_pb_reg + 41'd32768;

    // Stage 4: distance from the target rate
    always_comb
    begin
        s4_up_next   = s3_rate_reg > coef.target_rate;
        s4_diff_next = s4_up_next ? (s3_rate_reg - coef.target_rate)
                                  : (coef.target_rate - s3_rate_reg);
    end

    // Stage 5: rounded step magnitude
    always_comb
    begin
        step_prod  = 40'(s4_diff_reg) * 40'(coef.gain);
        step_round = {1'b0, step_prod} + 41'd128;
    end

    // Stage 6: apply the step
    always_comb
    begin
        if (s5_up_reg)
        begin
            s6_thr_next = $signed({11'b0, s5_thr_reg}) + $signed({2'b0, s5_step_reg});
        end
        else
        begin
            s6_thr_next = $signed({11'b0, s5_thr_reg}) - $signed({2'b0, s5_step_reg});
        end
    end

    // Clamp: floor first, ceiling wins
    always_comb
    begin
        floor_s = $signed({11'b0, coef.threshold_floor});
        ceil_s  = $signed({11'b0, coef.threshold_ceiling});
        thr_lo  = (s6_thr_reg < floor_s) ? floor_s : s6_thr_reg;
        if (thr_lo > ceil_s)
        begin
            thr_lo = ceil_s;
        end
        wb.tag  = s6_tag_reg;
        wb.rate = s6_rate_reg;
        wb.thr  = thr_lo[23:0];
    end

    assign pipe_busy = s1_tag_reg.valid | s2_tag_reg.valid | s3_tag_reg.valid
                     | s4_tag_reg.valid | s5_tag_reg.valid | s6_tag_reg.valid;

    // Tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
            s6_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
            s6_tag_reg <= s5_tag_reg;
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        s1_obs_reg  <= s1_obs_next;
        s1_avg_reg  <= avg_in;
        s1_thr_reg  <= thr_in;
        s2_pa_reg   <= s2_pa_next;
        s2_pb_reg   <= s2_pb_next;
        s2_thr_reg  <= s1_thr_reg;
        s3_rate_reg <= blend_sum[39:16];
        s3_thr_reg  <= s2_thr_reg;
        s4_rate_reg <= s3_rate_reg;
        s4_thr_reg  <= s3_thr_reg;
        s4_diff_reg <= s4_diff_next;
        s4_up_reg   <= s4_up_next;
        s5_rate_reg <= s4_rate_reg;
        s5_thr_reg  <= s4_thr_reg;
        s5_step_reg <= step_round[40:8];
        s5_up_reg   <= s4_up_reg;
        s6_rate_reg <= s5_rate_reg;
        s6_thr_reg  <= s6_thr_next;
    end

endmodule

`default_nettype wire
